// File: src/stbs_pkg.sv
// ============================================================================
// stbs_pkg
// Shared types and codes for the sorted table binary search block: the
// command and result words, the configuration register indexes and the
// search sequencer states.
// ============================================================================
package stbs_pkg;

  // Default sizes of the key table
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  // Fixed field widths of the command and result words
  localparam int INDEX_W = 10;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 10;

  // Configuration port widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_SIGNED = 2'd1;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Command word
  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]   key_value;
    logic               exact_match;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

endpackage

// File: src/sorted_table_binary_search.sv
// ============================================================================
// sorted_table_binary_search
// Sorted key table with a lower-bound / exact-match binary search engine
// built around one table read port and one shared key comparator.
// ============================================================================
// A write command (cmd 0) stores its key and leaves busy low, so writes
// may follow back to back. A search command (cmd 1) raises busy and runs
// halving steps: ST_READ reads the middle entry through the registered
// table read port, and ST_CMP then compares it with the search key in the
// shared comparator. With n = min(entry_count, depth) a search runs at most
// s = floor(log2(n)) + 1 steps (none for an empty table; a step that moves
// the lower bound can close the range early). out_valid pulses for one
// cycle, rising in the same cycle that busy falls. The result is shown for
// that single cycle only and is not held: capture it when out_valid is high.
// A new command may be started in that same cycle. Configuration writes are
// always taken (cfg_ready stays high) and must be made only while no search
// is running. Entries must be searched only after they have been written;
// the block itself does not enforce this.
// ============================================================================
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_item,
  // result channel
  output logic                   out_valid,
  output out_item_t              out_item,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // Key table
  logic [KEY_WIDTH-1:0] table_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;

  // Configuration registers
  logic [CFG_DATA_W-1:0] entry_count_r;
  logic                  compare_signed_r;

  // Sequencer and datapath registers
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic [KEY_WIDTH-1:0] target_r, target_nxt;
  logic                 exact_r, exact_nxt;
  logic                 eq_r, eq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 accept;
  logic                 wr_en;
  logic [CNT_W:0]       mid_sum;
  logic [KEY_WIDTH-1:0] sign_mask;
  logic [KEY_WIDTH-1:0] key_ord;
  logic                 key_le;
  logic                 key_eq;
  logic [CNT_W-1:0]     n_clip;

  assign accept    = start && !busy;
  assign wr_en     = accept && (in_item.cmd == CMD_WRITE) &&
                     (32'(in_item.entry_index) < 32'(TABLE_DEPTH));
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Midpoint of the live range and read address
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign rd_addr = mid_sum[IDX_W:1];

  // Shared comparator: flip sign bits to compare two's complement as unsigned
  assign sign_mask = compare_signed_r ? SIGN_BIT : '0;
  assign key_ord   = rd_data_r ^ sign_mask;
  assign key_le    = (target_r <= key_ord);
  assign key_eq    = (target_r == key_ord);

  // Clip the entry count to the table depth
  assign n_clip = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entry_count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.cmd == CMD_SEARCH)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP: begin
        state_nxt = ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and result word
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    n_nxt         = n_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    exact_nxt     = exact_r;
    eq_nxt        = eq_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        // load a new search
        if (accept && (in_item.cmd == CMD_SEARCH)) begin
          lo_nxt     = '0;
          hi_nxt     = n_clip;
          n_nxt      = n_clip;
          target_nxt = KEY_WIDTH'(in_item.key_value) ^ sign_mask;
          exact_nxt  = in_item.exact_match;
          eq_nxt     = 1'b0;
        end
      end
      ST_READ: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_sum[CNT_W:1];
        end else begin
          // range closed: report the lower bound, or not found with position 0
          out_valid_nxt         = 1'b1;
          out_item_nxt.found    = (lo_r < n_r) && (!exact_r || eq_r);
          out_item_nxt.position = out_item_nxt.found ? POS_W'(lo_r) : '0;
        end
      end
      ST_CMP: begin
        // narrow the range; remember equality at the new upper bound
        if (key_le) begin
          hi_nxt = mid_r;
          eq_nxt = key_eq;
        end else begin
          lo_nxt = mid_r + CNT_W'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[IDX_W'(in_item.entry_index)] <= KEY_WIDTH'(in_item.key_value);
    end
    rd_data_r <= table_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      entry_count_r    <= '0;
      compare_signed_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT:    entry_count_r    <= cfg_data;
          CFG_COMPARE_SIGNED: compare_signed_r <= cfg_data[0];
          default: begin
            entry_count_r <= entry_count_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    n_r        <= n_nxt;
    mid_r      <= mid_nxt;
    target_r   <= target_nxt;
    exact_r    <= exact_nxt;
    eq_r       <= eq_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTHESIS
  // A result only follows a closed search range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r == ST_READ) && $past(lo_r >= hi_r)))
    else $error("result strobe without a finished search");

  // The live range stays ordered and inside the entry count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((lo_r <= hi_r) && (hi_r <= n_r)))
    else $error("search range out of order");

  // An accepted search raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == CMD_SEARCH)) |=> busy)
    else $error("search accepted without going busy");

  // A write command never raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == CMD_WRITE)) |=> !busy)
    else $error("write command raised busy");
`endif

endmodule
